[hw/rtl/bsmv_pkg.sv]
`timescale 1ns / 1ps

package bsmv_pkg;

  localparam int MaxVec       = 64;
  localparam int MaxBlockRows = 16;

  // Field widths of the command, result and configuration items.
  localparam int IdxW    = 6;
  localparam int BrW     = 4;
  localparam int VecLenW = 7;
  localparam int NbrW    = 5;
  localparam int SelW    = 4;
  localparam int ValW    = 32;
  localparam int YW      = 48;
  localparam int FracW   = 16;
  localparam int ProdW   = 2 * ValW;

  // Derived storage widths.
  localparam int XAW  = $clog2(MaxVec);
  localparam int BndW = $clog2(MaxVec + 1);
  localparam int BaW  = $clog2(MaxBlockRows);

  typedef enum logic [2:0] {
    FnClear  = 3'd0,
    FnBound  = 3'd1,
    FnWriteX = 3'd2,
    FnHeader = 3'd3,
    FnValue  = 3'd4,
    FnReadY  = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StSize    = 2'd1,
    StRange   = 2'd2,
    StNoBlock = 2'd3
  } status_e;

  typedef struct packed {
    func_e                   func;
    logic [IdxW-1:0]         index;
    logic [BrW-1:0]          block_row;
    logic [BrW-1:0]          block_col;
    logic signed [ValW-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic signed [YW-1:0] y_value;
    status_e              status;
  } res_t;

  typedef struct packed {
    logic [VecLenW-1:0] vector_length;
    logic [NbrW-1:0]    num_block_rows;
    logic               row_only_mode;
    logic [SelW-1:0]    selected_row;
  } cfg_t;

  // Decoded operation handed from the control stage to the datapath.
  typedef struct packed {
    logic                   vld;
    logic                   clr;
    logic                   rd;
    logic                   mac;
    logic                   xwe;
    logic [XAW-1:0]         x_addr;
    logic [XAW-1:0]         y_addr;
    logic signed [ValW-1:0] val;
    status_e                status;
  } op_t;

endpackage

[hw/rtl/bsmv_ctrl.sv]
`timescale 1ns / 1ps

module bsmv_ctrl import bsmv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic accept_i,
  input  cmd_t cmd_i,
  input  cfg_t cfg_i,
  output op_t  op_o
);

  localparam int NumRd    = 5;
  localparam int PRowEnd  = 0;
  localparam int PRowBeg  = 1;
  localparam int PColEnd  = 2;
  localparam int PColBeg  = 3;
  localparam int PLast    = 4;

  cmd_t cmd_q;
  logic vld_q;

  logic [BndW-1:0] bnd_mem [NumRd][MaxBlockRows];
  logic [BndW-1:0] bnd_rd_q [NumRd];
  logic [BaW-1:0]  rd_addr [NumRd];
  logic [MaxBlockRows-1:0] bnd_vld_q;
  logic            bnd_we;
  logic [BaW-1:0]  bnd_waddr;
  logic [BndW-1:0] bnd_wdata;

  logic            open_q, open_d;
  logic            skip_q, skip_d;
  logic [BndW-1:0] row_start_q, row_start_d;
  logic [BndW-1:0] col_start_q, col_start_d;
  logic [BndW-1:0] height_q, height_d;
  logic [BndW-1:0] width_q, width_d;
  logic [XAW-1:0]  elem_row_q, elem_row_d;
  logic [XAW-1:0]  elem_col_q, elem_col_d;

  logic [BaW-1:0]  row_prev, col_prev, last_addr;
  logic [BndW-1:0] row_end, row_beg, col_end, col_beg, last_bnd;
  logic [BndW-1:0] y_idx, x_idx, row_inc, col_inc;
  logic            nbr_bad, brow_bad, bcol_bad, sel_bad;
  op_t             op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      cmd_q <= cmd_i;
    end
  end

  // The boundary table is read at five places per header, so it is kept as
  // five copies that share the write port. Reads start when the item is taken.
  always_comb begin
    rd_addr[PRowEnd] = cmd_i.block_row[BaW-1:0];
    rd_addr[PRowBeg] = cmd_i.block_row[BaW-1:0] - 1'b1;
    rd_addr[PColEnd] = cmd_i.block_col[BaW-1:0];
    rd_addr[PColBeg] = cmd_i.block_col[BaW-1:0] - 1'b1;
    rd_addr[PLast]   = cfg_i.num_block_rows[BaW-1:0] - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < NumRd; p++) begin
      if (bnd_we) begin
        bnd_mem[p][bnd_waddr] <= bnd_wdata;
      end
      if (bnd_we && bnd_waddr == rd_addr[p]) begin
        bnd_rd_q[p] <= bnd_wdata;
      end else begin
        bnd_rd_q[p] <= bnd_mem[p][rd_addr[p]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bnd_vld_q <= '0;
    end else if (bnd_we) begin
      bnd_vld_q[bnd_waddr] <= 1'b1;
    end
  end

  always_comb begin
    row_prev  = cmd_q.block_row[BaW-1:0] - 1'b1;
    col_prev  = cmd_q.block_col[BaW-1:0] - 1'b1;
    last_addr = cfg_i.num_block_rows[BaW-1:0] - 1'b1;

    // Entries never written read as zero; block zero starts at zero.
    row_end  = bnd_vld_q[cmd_q.block_row[BaW-1:0]] ? bnd_rd_q[PRowEnd] : '0;
    col_end  = bnd_vld_q[cmd_q.block_col[BaW-1:0]] ? bnd_rd_q[PColEnd] : '0;
    row_beg  = (cmd_q.block_row == '0 || !bnd_vld_q[row_prev]) ? '0 : bnd_rd_q[PRowBeg];
    col_beg  = (cmd_q.block_col == '0 || !bnd_vld_q[col_prev]) ? '0 : bnd_rd_q[PColBeg];
    last_bnd = bnd_vld_q[last_addr] ? bnd_rd_q[PLast] : '0;

    nbr_bad  = (cfg_i.num_block_rows == '0) || (int'(cfg_i.num_block_rows) > MaxBlockRows);
    brow_bad = {1'b0, cmd_q.block_row} >= cfg_i.num_block_rows;
    bcol_bad = {1'b0, cmd_q.block_col} >= cfg_i.num_block_rows;
    sel_bad  = cfg_i.row_only_mode && ({1'b0, cfg_i.selected_row} >= cfg_i.num_block_rows);

    y_idx   = (cfg_i.row_only_mode ? '0 : row_start_q) + BndW'(elem_row_q);
    x_idx   = col_start_q + BndW'(elem_col_q);
    row_inc = BndW'(elem_row_q) + 1'b1;
    col_inc = BndW'(elem_col_q) + 1'b1;

    op        = '0;
    op.vld    = vld_q;
    op.val    = cmd_q.value;
    op.x_addr = x_idx[XAW-1:0];
    op.y_addr = cmd_q.index[XAW-1:0];
    op.status = StOk;

    bnd_we    = 1'b0;
    bnd_waddr = cmd_q.index[BaW-1:0];
    bnd_wdata = cmd_q.value[BndW-1:0];

    open_d      = open_q;
    skip_d      = skip_q;
    row_start_d = row_start_q;
    col_start_d = col_start_q;
    height_d    = height_q;
    width_d     = width_q;
    elem_row_d  = elem_row_q;
    elem_col_d  = elem_col_q;

    if (vld_q) begin
      unique case (cmd_q.func)
        FnClear: begin
          op.clr = 1'b1;
        end
        FnBound: begin
          if (int'(cmd_q.index) >= MaxBlockRows || cmd_q.value < 0 || cmd_q.value > MaxVec) begin
            op.status = StRange;
          end else begin
            bnd_we = 1'b1;
          end
        end
        FnWriteX: begin
          if (int'(cmd_q.index) >= MaxVec) begin
            op.status = StRange;
          end else begin
            op.xwe    = 1'b1;
            op.x_addr = cmd_q.index[XAW-1:0];
          end
        end
        FnHeader: begin
          // Any failed header closes the open block.
          open_d = 1'b0;
          if (nbr_bad || brow_bad || bcol_bad || sel_bad) begin
            op.status = StRange;
          end else if (cfg_i.vector_length != last_bnd || row_end < row_beg ||
                       col_end < col_beg || row_end > cfg_i.vector_length ||
                       col_end > cfg_i.vector_length) begin
            op.status = StSize;
          end else begin
            row_start_d = row_beg;
            col_start_d = col_beg;
            height_d    = row_end - row_beg;
            width_d     = col_end - col_beg;
            elem_row_d  = '0;
            elem_col_d  = '0;
            skip_d      = cfg_i.row_only_mode && (cmd_q.block_row != cfg_i.selected_row);
            open_d      = (row_end != row_beg) && (col_end != col_beg);
          end
        end
        FnValue: begin
          if (!open_q) begin
            op.status = StNoBlock;
          end else begin
            op.y_addr = y_idx[XAW-1:0];
            op.mac    = !skip_q && int'(y_idx) < MaxVec && int'(x_idx) < MaxVec;
            // Values arrive column-major: walk down the rows, then step a column.
            if (row_inc >= height_q) begin
              elem_row_d = '0;
              elem_col_d = col_inc[XAW-1:0];
              if (col_inc >= width_q) begin
                open_d = 1'b0;
              end
            end else begin
              elem_row_d = row_inc[XAW-1:0];
            end
          end
        end
        FnReadY: begin
          if (int'(cmd_q.index) >= MaxVec) begin
            op.status = StRange;
          end else begin
            op.rd = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      skip_q      <= 1'b0;
      row_start_q <= '0;
      col_start_q <= '0;
      height_q    <= '0;
      width_q     <= '0;
      elem_row_q  <= '0;
      elem_col_q  <= '0;
    end else begin
      open_q      <= open_d;
      skip_q      <= skip_d;
      row_start_q <= row_start_d;
      col_start_q <= col_start_d;
      height_q    <= height_d;
      width_q     <= width_d;
      elem_row_q  <= elem_row_d;
      elem_col_q  <= elem_col_d;
    end
  end

  assign op_o = op;

endmodule

[hw/rtl/bsmv_acc.sv]
`timescale 1ns / 1ps

module bsmv_acc import bsmv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  op_t  op_i,
  output logic done_o,
  output res_t result_o
);

  localparam logic signed [YW-1:0] YMax = {1'b0, {(YW-1){1'b1}}};
  localparam logic signed [YW-1:0] YMin = {1'b1, {(YW-1){1'b0}}};

  op_t s2_q, s3_q;

  logic signed [ValW-1:0] x_mem [MaxVec];
  logic signed [ValW-1:0] x_rd_q;

  logic signed [ProdW-1:0] prod_d, prod_q;

  logic signed [YW-1:0] y_mem [MaxVec];
  logic signed [YW-1:0] y_rd_q;
  logic [MaxVec-1:0]    y_vld_q;
  logic                 y_vld_rd_q;
  logic                 byp_q;
  logic signed [YW-1:0] byp_data_q;

  logic signed [YW-1:0] y_old, rnd, y_new;
  logic signed [YW:0]   sum;
  logic                 s3_wr, byp_d;

  logic done_q;
  res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
      s3_q <= '0;
    end else begin
      s2_q <= op_i;
      s3_q <= s2_q;
    end
  end

  // x is written and read by the control stage, one item at a time.
  always_ff @(posedge clk_i) begin
    if (op_i.vld && op_i.xwe) begin
      x_mem[op_i.x_addr] <= op_i.val;
    end
    x_rd_q <= x_mem[op_i.x_addr];
  end

  assign prod_d = s2_q.val * x_rd_q;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Round to Q32.16: adding one half then flooring equals adding bit 15.
  assign rnd   = prod_q[FracW+YW-1:FracW] + YW'(prod_q[FracW-1]);
  assign y_old = byp_q ? byp_data_q : (y_vld_rd_q ? y_rd_q : '0);
  assign sum   = {y_old[YW-1], y_old} + {rnd[YW-1], rnd};

  always_comb begin
    if (sum[YW] != sum[YW-1]) begin
      y_new = sum[YW] ? YMin : YMax;
    end else begin
      y_new = sum[YW-1:0];
    end
  end

  assign s3_wr = s3_q.vld && s3_q.mac;

  // The read for the next item overlaps the write of this one; a write to the
  // same entry, or a clear, is forwarded into the read register.
  assign byp_d = s3_q.vld && (s3_q.clr || (s3_q.mac && s3_q.y_addr == s2_q.y_addr));

  always_ff @(posedge clk_i) begin
    if (s3_wr) begin
      y_mem[s3_q.y_addr] <= y_new;
    end
    y_rd_q     <= y_mem[s2_q.y_addr];
    byp_data_q <= s3_q.clr ? '0 : y_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_vld_q    <= '0;
      y_vld_rd_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      y_vld_rd_q <= y_vld_q[s2_q.y_addr];
      byp_q      <= byp_d;
      if (s3_q.vld && s3_q.clr) begin
        y_vld_q <= '0;
      end else if (s3_wr) begin
        y_vld_q[s3_q.y_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s3_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.y_value <= (s3_q.rd && s3_q.status == StOk) ? y_old : '0;
    res_q.status  <= s3_q.status;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

[hw/rtl/block_sparse_matvec_core.sv]
`timescale 1ns / 1ps

// Block-sparse matrix-vector accumulator: y (+)= A*x with Q16.16 operands and a
// saturating Q32.16 y. A command item is taken at every clock edge where start
// is high; busy never rises, so one item per cycle is sustained, and every item
// gives exactly one result, strobed by done_o for a single cycle once the item
// has passed the control stage, multiply stage, y read-modify-write stage and
// result register. The receiver cannot stall: results must be captured in the
// cycle done_o is high. Writes to y by one value item are forwarded to the next,
// so value items may follow each other back to back. Configuration registers
// may only be written while no item is in flight.
module block_sparse_matvec_core import bsmv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd_i,
  output logic             done_o,
  output res_t             result_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [VecLenW-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    CfgVecLen  = 2'd0,
    CfgNumRows = 2'd1,
    CfgRowOnly = 2'd2,
    CfgSelRow  = 2'd3
  } cfg_reg_e;

  cfg_t cfg_q;
  logic accept;
  op_t  op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vector_length  <= VecLenW'(MaxVec);
      cfg_q.num_block_rows <= NbrW'(MaxBlockRows);
      cfg_q.row_only_mode  <= 1'b0;
      cfg_q.selected_row   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgVecLen:  cfg_q.vector_length  <= cfg_data_i;
        CfgNumRows: cfg_q.num_block_rows <= cfg_data_i[NbrW-1:0];
        CfgRowOnly: cfg_q.row_only_mode  <= cfg_data_i[0];
        CfgSelRow:  cfg_q.selected_row   <= cfg_data_i[SelW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign busy   = 1'b0;
  assign accept = start && !busy;

  bsmv_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (cmd_i),
    .cfg_i    (cfg_q),
    .op_o     (op)
  );

  bsmv_acc u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (op),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule
